// ===== hw/rtl/gb11_pkg.sv =====
// Shared types, constants and sizes for the 11x11 Gaussian blur.
// Depends on nothing; the window, the MAC and the top level import it.
`timescale 1ns / 1ps

package gb11_pkg;

   // Frame geometry and kernel shape.
   localparam int IMG_WIDTH  = 512;
   localparam int IMG_HEIGHT = 512;
   localparam int KSIZE      = 11;
   localparam int KHALF      = KSIZE / 2;
   localparam int NUM_TAPS   = KHALF + 1;
   localparam int NUM_STEPS  = NUM_TAPS * NUM_TAPS;

   // Field and datapath widths.
   localparam int PIX_W      = 8;
   localparam int WEIGHT_W   = 16;
   localparam int COL_W      = $clog2(IMG_WIDTH);
   localparam int ROW_W      = $clog2(IMG_HEIGHT);
   localparam int TAP_IDX_W  = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int LINE_W     = (KSIZE - 1) * PIX_W;
   localparam int FOLD_W     = PIX_W + 2;
   localparam int P1_W       = WEIGHT_W + FOLD_W;
   localparam int INNER_W    = P1_W + 3;
   localparam int P2_W       = WEIGHT_W + INNER_W;
   localparam int ACC_W      = P2_W + 3;
   localparam int FRAC_SHIFT = 2 * WEIGHT_W;

   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef weight_type [NUM_TAPS-1:0] weight_set_type;

   // One window column, element 0 the oldest row.
   typedef logic [KSIZE-1:0][PIX_W-1:0] col_type;

   localparam weight_set_type TAP_RESET = {
      16'd0, 16'd9, 16'd290, 16'd3538, 16'd15858, 16'd26145
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_CALC,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic advance;
   } win_ctrl_type;

   typedef struct packed {
      logic advance;
      logic done;
   } mac_stat_type;

endpackage

// ===== hw/rtl/gb11_line_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
// Depends on nothing; holds the column history of the last rows.
`timescale 1ns / 1ps

module gb11_line_ram #(
   parameter int DEPTH  = 512,
   parameter int DATA_W = 80,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/gb11_window.sv =====
// 11x11 pixel window and the queue of symmetric tap sums fed to the MAC.
// Depends on gb11_pkg.
`timescale 1ns / 1ps

module gb11_window
   import gb11_pkg::*;
(
   input  logic              clock,
   input  win_ctrl_type      ctrl,
   input  col_type           col_in,
   output logic [FOLD_W-1:0] q_head
);

   col_type           win_ff   [KSIZE];
   logic [FOLD_W-1:0] chain_ff [NUM_STEPS];
   logic [PIX_W:0]    cfold    [NUM_TAPS][KSIZE];
   logic [FOLD_W-1:0] qv       [NUM_STEPS];

   // Pixels at equal distance from the centre share a weight, so the
   // window folds onto itself in both directions before any multiply.
   always_comb begin
      for (int d = 0; d < NUM_TAPS; d++) begin
         for (int row = 0; row < KSIZE; row++) begin
            if (d == 0) begin
               cfold[d][row] = {1'b0, win_ff[KHALF][row]};
            end else begin
               cfold[d][row] = {1'b0, win_ff[KHALF+d][row]}
                             + {1'b0, win_ff[KHALF-d][row]};
            end
         end
      end
      for (int e = 0; e < NUM_TAPS; e++) begin
         for (int d = 0; d < NUM_TAPS; d++) begin
            if (e == 0) begin
               qv[e*NUM_TAPS+d] = {1'b0, cfold[d][KHALF]};
            end else begin
               qv[e*NUM_TAPS+d] = {1'b0, cfold[d][KHALF+e]}
                                + {1'b0, cfold[d][KHALF-e]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         for (int k = 0; k < KSIZE - 1; k++) begin
            win_ff[k] <= win_ff[k+1];
         end
         win_ff[KSIZE-1] <= col_in;
      end
   end

   // Sums leave in step order: row distance outer, column distance inner.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         for (int s = 0; s < NUM_STEPS; s++) begin
            chain_ff[s] <= qv[s];
         end
      end else if (ctrl.advance) begin
         for (int s = 0; s < NUM_STEPS - 1; s++) begin
            chain_ff[s] <= chain_ff[s+1];
         end
      end
   end

   assign q_head = chain_ff[0];

endmodule

// ===== hw/rtl/gb11_mac.sv =====
// Two-level multiply-accumulate sequencer for the separable kernel.
// Depends on gb11_pkg.
`timescale 1ns / 1ps

module gb11_mac
   import gb11_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  weight_set_type    weights,
   input  logic [FOLD_W-1:0] q_head,
   output mac_stat_type      stat,
   output logic [PIX_W-1:0]  result
);

   localparam logic [TAP_IDX_W-1:0] LAST_TAP = TAP_IDX_W'(NUM_TAPS - 1);

   logic                 run_ff;
   logic [TAP_IDX_W-1:0] d_ff;
   logic [TAP_IDX_W-1:0] e_ff;
   weight_set_type       wd_ring_ff;
   weight_set_type       we_ring_ff;

   logic                 p1_vld_ff;
   logic [P1_W-1:0]      p1_ff;
   logic                 p1_first_ff;
   logic                 p1_last_ff;
   weight_type           p1_we_ff;
   logic                 p1_efirst_ff;
   logic                 p1_elast_ff;

   logic                 sum_vld_ff;
   logic [INNER_W-1:0]   inner_ff;
   weight_type           sum_we_ff;
   logic                 sum_efirst_ff;
   logic                 sum_elast_ff;

   logic                 p2_vld_ff;
   logic [P2_W-1:0]      p2_ff;
   logic                 p2_first_ff;
   logic                 p2_last_ff;

   logic [ACC_W-1:0]     outer_ff;
   logic                 done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 1'b0;
         d_ff       <= '0;
         e_ff       <= '0;
         p1_vld_ff  <= 1'b0;
         sum_vld_ff <= 1'b0;
         p2_vld_ff  <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         if (start) begin
            run_ff <= 1'b1;
            d_ff   <= '0;
            e_ff   <= '0;
         end else if (run_ff) begin
            if (d_ff == LAST_TAP) begin
               d_ff <= '0;
               if (e_ff == LAST_TAP) begin
                  run_ff <= 1'b0;
               end else begin
                  e_ff <= e_ff + 1'b1;
               end
            end else begin
               d_ff <= d_ff + 1'b1;
            end
         end
         p1_vld_ff  <= run_ff;
         sum_vld_ff <= p1_vld_ff & p1_last_ff;
         p2_vld_ff  <= sum_vld_ff;
         done_ff    <= p2_vld_ff & p2_last_ff;
      end
   end

   // Weight rings: the column weight turns every step, the row weight
   // once per completed row distance.
   always_ff @(posedge clock) begin
      if (start) begin
         wd_ring_ff <= weights;
         we_ring_ff <= weights;
      end else if (run_ff) begin
         wd_ring_ff <= {wd_ring_ff[0], wd_ring_ff[NUM_TAPS-1:1]};
         if (d_ff == LAST_TAP) begin
            we_ring_ff <= {we_ring_ff[0], we_ring_ff[NUM_TAPS-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (run_ff) begin
         p1_ff        <= P1_W'(wd_ring_ff[0]) * P1_W'(q_head);
         p1_first_ff  <= (d_ff == '0);
         p1_last_ff   <= (d_ff == LAST_TAP);
         p1_we_ff     <= we_ring_ff[0];
         p1_efirst_ff <= (e_ff == '0);
         p1_elast_ff  <= (e_ff == LAST_TAP);
      end
      if (p1_vld_ff) begin
         inner_ff <= p1_first_ff ? INNER_W'(p1_ff) : inner_ff + INNER_W'(p1_ff);
         if (p1_last_ff) begin
            sum_we_ff     <= p1_we_ff;
            sum_efirst_ff <= p1_efirst_ff;
            sum_elast_ff  <= p1_elast_ff;
         end
      end
      if (sum_vld_ff) begin
         p2_ff       <= P2_W'(sum_we_ff) * P2_W'(inner_ff);
         p2_first_ff <= sum_efirst_ff;
         p2_last_ff  <= sum_elast_ff;
      end
      if (p2_vld_ff) begin
         outer_ff <= p2_first_ff ? ACC_W'(p2_ff) : outer_ff + ACC_W'(p2_ff);
      end
   end

   assign result = (|outer_ff[ACC_W-1:FRAC_SHIFT+PIX_W]) ? {PIX_W{1'b1}}
                 : outer_ff[FRAC_SHIFT+PIX_W-1:FRAC_SHIFT];

   assign stat.advance = run_ff;
   assign stat.done    = done_ff;

   a_start_when_empty: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff && !p1_vld_ff && !sum_vld_ff && !p2_vld_ff)
      else $error("MAC started while a previous sum was still in flight");

   a_done_after_issue: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff && !p1_vld_ff)
      else $error("MAC signalled completion with products still pending");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("MAC completion held for more than one cycle");

endmodule

// ===== hw/rtl/gaussian_blur_11x11.sv =====
// Top level of the streaming 11x11 Gaussian blur: control, counters,
// weight registers and output register. Depends on gb11_pkg, gb11_line_ram,
// gb11_window and gb11_mac.
//
//   Channel  Direction  Handshake             Payload
//   req_     in         req_valid/req_ready   req_pixel_in[7:0]
//   rsp_     out        rsp_valid/rsp_ready   rsp_pixel_out[7:0], rsp_frame_last
//   csr_     in         csr_valid/csr_ready   csr_index[2:0], csr_data[15:0]
//
// A border pixel passes through the fetch state, which writes the line store,
// and returns straight to idle. An interior pixel needs the 36 steps of the
// single shared multiply-accumulate unit over the folded 6x6 tap grid, plus
// the line store read, window load and MAC pipeline. Reset clears the counters,
// the control state and restores the default weights; the line store is not
// cleared, since every window read lies in rows already written this frame.
// A stalled result waits in the output register while the next input
// transaction is accepted and processed; only its completion waits.
`timescale 1ns / 1ps

module gaussian_blur_11x11
   import gb11_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIX_W-1:0]     req_pixel_in,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PIX_W-1:0]     rsp_pixel_out,
   output logic                 rsp_frame_last,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WEIGHT_W-1:0]  csr_data
);

   state_type          state_ff, state_in;
   logic [COL_W-1:0]   col_count_ff, col_count_in;
   logic [ROW_W-1:0]   row_count_ff, row_count_in;
   weight_set_type     weight_ff;

   // Details of the transaction in progress.
   logic [PIX_W-1:0]   pix_ff;
   logic [COL_W-1:0]   col_ff;
   logic               interior_ff;
   logic               last_ff;

   logic               rsp_valid_ff;
   logic [PIX_W-1:0]   rsp_pixel_ff;
   logic               rsp_last_ff;

   logic               req_accept;
   logic               out_free;
   logic               out_load;
   logic               ram_rd_en;
   logic               ram_wr_en;
   logic               mac_start;
   win_ctrl_type       win_ctrl;
   mac_stat_type       mac_stat;
   logic [LINE_W-1:0]  ram_rd_data;
   logic [LINE_W-1:0]  ram_wr_data;
   col_type            new_col;
   logic [FOLD_W-1:0]  q_head;
   logic [PIX_W-1:0]   mac_result;

   assign req_accept = req_valid & req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // The line store keeps, per column, the ten rows above the current one.
   // The new pixel joins them to make the window column, and the oldest
   // row drops out when the entry is written back.
   assign new_col     = {pix_ff, ram_rd_data};
   assign ram_wr_data = {pix_ff, ram_rd_data[LINE_W-1:PIX_W]};
   assign ram_wr_en   = (state_ff == ST_FETCH);

   // Weight registers. Writes to an index beyond the last tap are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= TAP_RESET;
      end else if (csr_valid && csr_ready && csr_index < CSR_IDX_W'(NUM_TAPS)) begin
         weight_ff[csr_index] <= csr_data;
      end
   end

   // Raster position of the next input pixel.
   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (req_accept) begin
         if (col_count_ff == COL_W'(IMG_WIDTH - 1)) begin
            col_count_in = '0;
            if (row_count_ff == ROW_W'(IMG_HEIGHT - 1)) begin
               row_count_in = '0;
            end else begin
               row_count_in = row_count_ff + 1'b1;
            end
         end else begin
            col_count_in = col_count_ff + 1'b1;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_FETCH;
         ST_FETCH: state_in = interior_ff ? ST_LOAD : ST_IDLE;
         ST_LOAD:  state_in = ST_CALC;
         ST_CALC:  if (mac_stat.done) state_in = ST_HOLD;
         ST_HOLD:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready        = 1'b0;
      win_ctrl.shift   = 1'b0;
      win_ctrl.load    = 1'b0;
      win_ctrl.advance = mac_stat.advance;
      mac_start        = 1'b0;
      out_load         = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_FETCH: win_ctrl.shift = 1'b1;
         ST_LOAD: begin
            win_ctrl.load = 1'b1;
            mac_start     = 1'b1;
         end
         ST_CALC:  ;
         ST_HOLD:  out_load = out_free;
         default:  ;
      endcase
   end

   assign ram_rd_en = req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_count_ff <= '0;
         row_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // A result exists once the window is complete: ten full rows and ten
   // pixels of the current row lie behind the incoming pixel.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pix_ff      <= req_pixel_in;
         col_ff      <= col_count_ff;
         interior_ff <= (col_count_ff >= COL_W'(KSIZE - 1))
                     && (row_count_ff >= ROW_W'(KSIZE - 1));
         last_ff     <= (col_count_ff == COL_W'(IMG_WIDTH - 1))
                     && (row_count_ff == ROW_W'(IMG_HEIGHT - 1));
      end
      if (out_load) begin
         rsp_pixel_ff <= mac_result;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_frame_last = rsp_last_ff;

   gb11_line_ram #(
      .DEPTH  (IMG_WIDTH),
      .DATA_W (LINE_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (col_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (col_count_ff),
      .rd_data (ram_rd_data)
   );

   gb11_window u_window (
      .clock  (clock),
      .ctrl   (win_ctrl),
      .col_in (new_col),
      .q_head (q_head)
   );

   gb11_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .start   (mac_start),
      .weights (weight_ff),
      .q_head  (q_head),
      .stat    (mac_stat),
      .result  (mac_result)
   );

   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      mac_stat.done |-> state_ff == ST_CALC)
      else $error("MAC completion outside the calculation state");

   a_border_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH && !interior_ff) |=> state_ff == ST_IDLE)
      else $error("Border pixel did not return straight to idle");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_ff) |-> (col_count_ff == '0 && row_count_ff == '0))
      else $error("Frame end result without the raster counters wrapping");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_count_ff <= COL_W'(IMG_WIDTH - 1))
      else $error("Column counter beyond the line width");

endmodule
